[rtl/size_sorted_free_list_top_macros.svh]
// Assertion macros used by the free list top module.
`ifndef SIZE_SORTED_FREE_LIST_TOP_MACROS_SVH
`define SIZE_SORTED_FREE_LIST_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SSFL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("free list check failed");
`define SSFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("free list check failed");
`else
`define SSFL_ASSERT_SAME(lbl, ante, cons)
`define SSFL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/ssfl_pkg.sv]
// Shared constants and types of the size sorted free list.
package ssfl_pkg;

  localparam int DEPTH     = 16;
  localparam int ADDR_BITS = 32;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_FIT    = 2'd2;
  localparam logic [1:0] MODE_LAST   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic                 ins;
    logic                 del;
    logic                 fit;
    logic                 last;
    logic [ADDR_BITS-1:0] addr;
    logic [DATA_W-1:0]    size;
  } op_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] addr;
    logic [DATA_W-1:0]    size;
    logic                 ins_at;
    logic                 del_seen;
    logic                 fit_seen;
  } link_t;

  typedef struct packed {
    logic                 hit;
    logic [ADDR_BITS-1:0] addr;
    logic [DATA_W-1:0]    size;
  } res_t;

endpackage

[rtl/ssfl_cell.sv]
// One entry cell of the sorted free list chain.
module ssfl_cell (
  input  logic           clk,
  input  logic           rst,
  input  ssfl_pkg::op_t  op,
  input  ssfl_pkg::link_t nbr_prev,
  input  ssfl_pkg::link_t nbr_next,
  output ssfl_pkg::link_t link,
  output ssfl_pkg::res_t  res
);

  logic                           valid;
  logic                           valid_next;
  logic [ssfl_pkg::ADDR_BITS-1:0] addr;
  logic [ssfl_pkg::ADDR_BITS-1:0] addr_next;
  logic [ssfl_pkg::DATA_W-1:0]    size;
  logic [ssfl_pkg::DATA_W-1:0]    size_next;
  logic                           ins_at;
  logic                           del_seen;
  logic                           fit_me;
  logic                           last_me;
  logic                           load;

  assign ins_at   = !valid || (size > op.size);
  assign del_seen = nbr_prev.del_seen || (valid && (addr == op.addr));
  assign fit_me   = valid && (size >= op.size);
  assign last_me  = valid && !nbr_next.valid;

  assign link.valid    = valid;
  assign link.addr     = addr;
  assign link.size     = size;
  assign link.ins_at   = ins_at;
  assign link.del_seen = del_seen;
  assign link.fit_seen = nbr_prev.fit_seen || fit_me;

  always_comb begin
    res.hit = (op.fit && fit_me && !nbr_prev.fit_seen) || (op.last && last_me);
    res.addr = res.hit ? addr : '0;
    res.size = res.hit ? size : '0;
  end

  always_comb begin
    load       = 1'b0;
    valid_next = valid;
    addr_next  = addr;
    size_next  = size;
    if (op.ins && ins_at) begin
      load       = 1'b1;
      valid_next = valid || nbr_prev.valid || !nbr_prev.ins_at;
      if (nbr_prev.ins_at) begin
        addr_next = nbr_prev.addr;
        size_next = nbr_prev.size;
      end else begin
        addr_next = op.addr;
        size_next = op.size;
      end
    end else if (op.del && del_seen) begin
      load       = 1'b1;
      valid_next = nbr_next.valid;
      addr_next  = nbr_next.addr;
      size_next  = nbr_next.size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr <= addr_next;
      size <= size_next;
    end
  end

endmodule

[rtl/size_sorted_free_list_top.sv]
// Size sorted free list: a chain of entry cells kept in ascending size order.
// The block takes one operation per clock cycle while in_ready is high: an
// insert, a delete by address, a best fit query or a largest block query
// each finish in the cycle they are accepted; an insert with room or a delete
// that finds its entry updates the cell chain at that edge. The result goes to
// an output register, and in_ready stays high while that register is empty or
// being taken, so a stalled consumer holds the input back only once the output
// register is occupied. Delete and fit searches ripple a first-match flag
// combinationally through all cells. No clearing pass is needed after reset.
`include "size_sorted_free_list_top_macros.svh"

module size_sorted_free_list_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [31:0]                 block_addr,
  input  logic [31:0]                 block_size,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [31:0]                 found_addr,
  output logic [31:0]                 found_size,
  output logic [ssfl_pkg::CNT_W-1:0]  entry_count
);

  ssfl_pkg::op_t                   op;
  ssfl_pkg::link_t                 links [ssfl_pkg::DEPTH];
  ssfl_pkg::res_t                  results [ssfl_pkg::DEPTH];
  logic [ssfl_pkg::DEPTH-1:0]      valid_vec;
  logic [ssfl_pkg::CNT_W-1:0]      used_count;
  logic [ssfl_pkg::CNT_W-1:0]      used_count_next;
  logic [1:0]                      status_next;
  logic [ssfl_pkg::ADDR_BITS-1:0]  hit_addr;
  logic [ssfl_pkg::DATA_W-1:0]     hit_size;
  logic                            accept;
  logic                            full;
  logic                            empty;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (used_count == ssfl_pkg::CNT_W'(ssfl_pkg::DEPTH));
  assign empty    = (used_count == '0);

  always_comb begin
    op.ins  = accept && (mode == ssfl_pkg::MODE_INSERT) && !full;
    op.del  = accept && (mode == ssfl_pkg::MODE_DELETE);
    op.fit  = (mode == ssfl_pkg::MODE_FIT);
    op.last = (mode == ssfl_pkg::MODE_LAST);
    op.addr = ssfl_pkg::ADDR_BITS'(block_addr);
    op.size = ssfl_pkg::DATA_W'(block_size);
  end

  genvar g;
  generate
    for (g = 0; g < ssfl_pkg::DEPTH; g++) begin : gen_cell
      ssfl_pkg::link_t prev_link;
      ssfl_pkg::link_t next_link;
      if (g == 0) begin : gen_first
        assign prev_link = '0;
      end else begin : gen_mid
        assign prev_link = links[g-1];
      end
      if (g == ssfl_pkg::DEPTH - 1) begin : gen_end
        assign next_link = '0;
      end else begin : gen_body
        assign next_link = links[g+1];
      end
      ssfl_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .op       (op),
        .nbr_prev (prev_link),
        .nbr_next (next_link),
        .link     (links[g]),
        .res      (results[g])
      );
      assign valid_vec[g] = links[g].valid;
    end
  endgenerate

  always_comb begin
    hit_addr = '0;
    hit_size = '0;
    for (int i = 0; i < ssfl_pkg::DEPTH; i++) begin
      hit_addr = hit_addr | results[i].addr;
      hit_size = hit_size | results[i].size;
    end
  end

  always_comb begin
    used_count_next = used_count;
    status_next     = ssfl_pkg::ST_OK;
    case (mode)
      ssfl_pkg::MODE_INSERT: begin
        if (full) begin
          status_next = ssfl_pkg::ST_FULL;
        end else begin
          used_count_next = used_count + 1'b1;
        end
      end
      ssfl_pkg::MODE_DELETE: begin
        if (links[ssfl_pkg::DEPTH-1].del_seen) begin
          used_count_next = used_count - 1'b1;
        end else begin
          status_next = ssfl_pkg::ST_NOTFOUND;
        end
      end
      ssfl_pkg::MODE_FIT: begin
        if (empty) begin
          status_next = ssfl_pkg::ST_EMPTY;
        end else if (!links[ssfl_pkg::DEPTH-1].fit_seen) begin
          status_next = ssfl_pkg::ST_NOTFOUND;
        end
      end
      ssfl_pkg::MODE_LAST: begin
        if (empty) begin
          status_next = ssfl_pkg::ST_EMPTY;
        end
      end
      default: begin
        status_next = ssfl_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        used_count <= used_count_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      found_addr  <= 32'(hit_addr);
      found_size  <= 32'(hit_size);
      entry_count <= used_count_next;
    end
  end

  `SSFL_ASSERT_SAME(a_count_bound, 1'b1, used_count <= ssfl_pkg::CNT_W'(ssfl_pkg::DEPTH))
  `SSFL_ASSERT_SAME(a_count_matches_cells, 1'b1, $countones(valid_vec) == int'(used_count))
  `SSFL_ASSERT_NEXT(a_insert_grows, op.ins, used_count == $past(used_count) + 1'b1)
  `SSFL_ASSERT_NEXT(a_miss_keeps_cells,
    op.del && !links[ssfl_pkg::DEPTH-1].del_seen, $stable(valid_vec))

endmodule
